// ===== rtl/whsb_pkg.sv =====
package whsb_pkg;

  // Fraction bits of the smoothstep weights; a weight lies in 0..2^F.
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WT_W             = WEIGHT_FRAC_BITS + 1;

  // Field and register widths.
  localparam int PIX_W          = 8;
  localparam int GAIN_W         = 16;
  localparam int SHIFT_W        = 16;
  localparam int GAIN_FRAC_BITS = 14;
  localparam int SHIFT_FRAC_BITS = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SAT_GAIN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HUE_SHIFT = CFG_IDX_W'(1);

  // Ramp limits of the three weights.
  localparam int HUE_LO    = 5;
  localparam int HUE_HI    = 38;
  localparam int HUE_RAMP  = 6;
  localparam int SAT_LO    = 80;
  localparam int SAT_SPAN  = 30;
  localparam int VAL_LO    = 100;
  localparam int VAL_SPAN  = 40;
  localparam int HUE_MOD   = 180;
  localparam int PIX_MAX   = 255;

  // Depth of the queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Weight table selectors.
  localparam int LUT_HUE = 0;
  localparam int LUT_SAT = 1;
  localparam int LUT_VAL = 2;
  localparam int LUT_N   = 256;
  localparam int LUT_W   = LUT_N * WT_W;

  // One classified pixel word as it travels through the queue.
  typedef struct packed {
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] sat;
    logic [PIX_W-1:0] val;
    logic             last;
    logic [WT_W-1:0]  hw;
    logic [WT_W-1:0]  sw;
    logic [WT_W-1:0]  vw;
  } item_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Clamp helper for the table builder.
  function automatic longint clamp_span(input longint x, input longint span);
    longint r;
    r = x;
    if (r < 0) r = 0;
    if (r > span) r = span;
    return r;
  endfunction

  // Restoring long division of a non-negative numerator, used only while
  // the tables are built.
  function automatic longint quotient(input longint n, input longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int k = 62; k >= 0; k--) begin
      r = (r << 1) | ((n >> k) & longint'(1));
      if (r >= d) begin
        r = r - d;
        q = q | (longint'(1) << k);
      end
    end
    return q;
  endfunction

  // Builds one weight table at elaboration; entry i is the weight of byte i.
  function automatic logic [LUT_W-1:0] build_lut(input int kind);
    logic [LUT_W-1:0] lut;
    longint a;
    longint b;
    longint n;
    longint num;
    longint den;
    longint nmax;
    lut  = '0;
    nmax = HUE_RAMP * HUE_RAMP;
    for (int i = 0; i < LUT_N; i++) begin
      case (kind)
        LUT_HUE: begin
          if (i >= HUE_MOD) begin
            num = 0;
          end else begin
            a   = clamp_span(longint'(i) - HUE_LO, HUE_RAMP);
            b   = clamp_span(HUE_HI - longint'(i), HUE_RAMP);
            n   = a * b;
            num = n * n * (3 * nmax - 2 * n);
          end
          den = nmax * nmax * nmax;
        end
        LUT_SAT: begin
          n   = clamp_span(longint'(i) - SAT_LO, SAT_SPAN);
          num = n * n * (3 * SAT_SPAN - 2 * n);
          den = SAT_SPAN * SAT_SPAN * SAT_SPAN;
        end
        LUT_VAL: begin
          n   = clamp_span(longint'(i) - VAL_LO, VAL_SPAN);
          num = n * n * (3 * VAL_SPAN - 2 * n);
          den = VAL_SPAN * VAL_SPAN * VAL_SPAN;
        end
        default: begin
          num = 0;
          den = 1;
        end
      endcase
      lut[i*WT_W +: WT_W] = WT_W'(quotient(num << WEIGHT_FRAC_BITS, den));
    end
    return lut;
  endfunction

  localparam logic [LUT_W-1:0] HW_LUT = build_lut(LUT_HUE);
  localparam logic [LUT_W-1:0] SW_LUT = build_lut(LUT_SAT);
  localparam logic [LUT_W-1:0] VW_LUT = build_lut(LUT_VAL);

  // Table read by byte index.
  function automatic logic [WT_W-1:0] lut_read(input logic [LUT_W-1:0] lut,
                                               input logic [PIX_W-1:0] idx);
    return lut[idx*WT_W +: WT_W];
  endfunction

endpackage

// ===== rtl/whsb_front.sv =====
module whsb_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_hue,
  input  logic [7:0]           in_sat,
  input  logic [7:0]           in_val,
  input  logic                 in_last_pixel,
  input  whsb_pkg::q_status_t  q_status,
  output logic                 push_valid,
  output whsb_pkg::item_t      push_item
);
  import whsb_pkg::*;

  logic  f_valid_r;
  logic  f_valid_nxt;
  item_t f_item_r;
  item_t f_item_nxt;

  // The front register holds one word until the queue has room.
  assign in_stall   = f_valid_r && q_status.full;
  assign push_valid = f_valid_r && !q_status.full;
  assign push_item  = f_item_r;

  // Classify the incoming pixel: look up its three weights.
  always_comb begin
    f_item_nxt.hue  = in_hue;
    f_item_nxt.sat  = in_sat;
    f_item_nxt.val  = in_val;
    f_item_nxt.last = in_last_pixel;
    f_item_nxt.hw   = lut_read(HW_LUT, in_hue);
    f_item_nxt.sw   = lut_read(SW_LUT, in_sat);
    f_item_nxt.vw   = lut_read(VW_LUT, in_val);
    f_valid_nxt     = in_stall ? f_valid_r : in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule

// ===== rtl/whsb_queue.sv =====
module whsb_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  input  whsb_pkg::item_t      push_item,
  input  logic                 pop,
  output whsb_pkg::item_t      head_item,
  output whsb_pkg::q_status_t  q_status
);
  import whsb_pkg::*;

  item_t              entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r;
  logic [Q_CNT_W-1:0] count_nxt;

  assign q_status.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_status.empty = (count_r == '0);
  assign head_item      = entry_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_valid) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_valid && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push_valid) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_valid) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/whsb_back.sv =====
module whsb_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [whsb_pkg::GAIN_W-1:0]          sat_gain,
  input  logic signed [whsb_pkg::SHIFT_W-1:0]  hue_shift,
  input  whsb_pkg::item_t                      head_item,
  input  whsb_pkg::q_status_t                  q_status,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           out_hue,
  output logic [7:0]                           out_sat,
  output logic [7:0]                           out_value,
  output logic                                 out_last_pixel
);
  import whsb_pkg::*;

  localparam int F      = WEIGHT_FRAC_BITS;
  localparam int GH_W   = GAIN_W + WT_W;
  localparam int X2_W   = PIX_W + GH_W;
  localparam int SUM_W  = X2_W - GAIN_FRAC_BITS - F + 1;
  localparam int P_W    = SHIFT_W + WT_W + 1;
  localparam int PS_W   = P_W - SHIFT_FRAC_BITS - F;
  localparam int Q_W    = PS_W + 1;
  localparam logic signed [Q_W-1:0] MOD_Q  = Q_W'(HUE_MOD);
  localparam logic signed [Q_W-1:0] MOD2_Q = Q_W'(2 * HUE_MOD);

  typedef struct packed {
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] sat;
    logic [PIX_W-1:0] val;
    logic             last;
    logic [WT_W-1:0]  vw;
    logic [GH_W-1:0]  gain_hw;
    logic [WT_W-1:0]  hs;
  } s1_t;

  typedef struct packed {
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] sat;
    logic [PIX_W-1:0] val;
    logic             last;
    logic [WT_W-1:0]  cw;
  } s2_t;

  logic             adv;
  logic             s1_valid_r;
  logic             s2_valid_r;
  logic             out_valid_r;
  s1_t              s1_r;
  s1_t              s1_nxt;
  s2_t              s2_r;
  s2_t              s2_nxt;
  logic [PIX_W-1:0] hue_r;
  logic [PIX_W-1:0] hue_nxt;
  logic [PIX_W-1:0] sat_r;
  logic [PIX_W-1:0] val_r;
  logic             last_r;

  logic [2*WT_W-1:0]       hs_full;
  logic [X2_W-1:0]         x2;
  logic [SUM_W-1:0]        sat_sum;
  logic [2*WT_W-1:0]       cw_full;
  logic signed [P_W-1:0]   shift_prod;
  logic signed [PS_W-1:0]  shift_int;
  logic signed [Q_W-1:0]   hue_q;
  logic signed [Q_W-1:0]   hue_wrap;

  // The whole pipe moves whenever the output register can take a word.
  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && !q_status.empty;

  // Stage one: gain times hue weight, hue weight times saturation weight.
  always_comb begin
    hs_full        = head_item.hw * head_item.sw;
    s1_nxt.hue     = head_item.hue;
    s1_nxt.sat     = head_item.sat;
    s1_nxt.val     = head_item.val;
    s1_nxt.last    = head_item.last;
    s1_nxt.vw      = head_item.vw;
    s1_nxt.gain_hw = sat_gain * head_item.hw;
    s1_nxt.hs      = hs_full[F +: WT_W];
  end

  // Stage two: boosted saturation with clamp, combined hue weight.
  always_comb begin
    x2      = s1_r.sat * s1_r.gain_hw;
    sat_sum = SUM_W'(s1_r.sat) + SUM_W'(x2[X2_W-1:GAIN_FRAC_BITS+F]);
    cw_full = s1_r.hs * s1_r.vw;
    s2_nxt.hue  = s1_r.hue;
    s2_nxt.val  = s1_r.val;
    s2_nxt.last = s1_r.last;
    s2_nxt.cw   = cw_full[F +: WT_W];
    if (sat_gain == '0) begin
      s2_nxt.sat = s1_r.sat;
    end else if (sat_sum > SUM_W'(PIX_MAX)) begin
      s2_nxt.sat = PIX_W'(PIX_MAX);
    end else begin
      s2_nxt.sat = sat_sum[PIX_W-1:0];
    end
  end

  // Stage three: shifted hue, whole part, wrapped into one turn.
  always_comb begin
    shift_prod = hue_shift * $signed({1'b0, s2_r.cw});
    shift_int  = shift_prod[P_W-1 -: PS_W];
    hue_q      = $signed({{(Q_W-PIX_W){1'b0}}, s2_r.hue}) +
                 $signed({shift_int[PS_W-1], shift_int});
    if (hue_q < 0) begin
      hue_wrap = hue_q + MOD_Q;
    end else if (hue_q >= MOD2_Q) begin
      hue_wrap = hue_q - MOD2_Q;
    end else if (hue_q >= MOD_Q) begin
      hue_wrap = hue_q - MOD_Q;
    end else begin
      hue_wrap = hue_q;
    end
    hue_nxt = (hue_shift == '0) ? s2_r.hue : hue_wrap[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= !q_status.empty;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      hue_r  <= hue_nxt;
      sat_r  <= s2_r.sat;
      val_r  <= s2_r.val;
      last_r <= s2_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = hue_r;
  assign out_sat        = sat_r;
  assign out_value      = val_r;
  assign out_last_pixel = last_r;

endmodule

// ===== rtl/warm_hue_saturation_boost.sv =====
// Warm hue saturation boost for an 8-bit HSV pixel stream (hue in half degrees).
// Input channel: in_valid/in_stall with in_hue, in_sat, in_val, in_last_pixel.
// Output channel: out_valid/out_stall with out_hue, out_sat, out_value,
// out_last_pixel. A word moves on a channel at a clock edge where valid is
// high and stall is low.
// Configuration: cfg_wr_en, cfg_index, cfg_wdata; index 0 is sat_gain (Q2.14),
// index 1 is hue_shift (signed Q8.8); other indexes are ignored. Write only
// while the block holds no pixel.
// With out_stall low, throughput is one pixel per clock: every stage is a table
// lookup or one multiplier, and the queue and pipe hand a word on each cycle.
// From input acceptance to out_valid a word passes the front register, the
// queue, two multiply stages, then the output register.
// While a valid output is stalled the back pipe holds; the four-word queue and
// the front register keep absorbing input until they fill, then in_stall rises.
// Synchronous reset (rst_n low) empties the pipe and clears both registers
// to zero, so pixels pass through unchanged until configured.
module warm_hue_saturation_boost (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_hue,
  input  logic [7:0]  in_sat,
  input  logic [7:0]  in_val,
  input  logic        in_last_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_hue,
  output logic [7:0]  out_sat,
  output logic [7:0]  out_value,
  output logic        out_last_pixel,
  input  logic                                 cfg_wr_en,
  input  logic [whsb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [whsb_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import whsb_pkg::*;

  logic [GAIN_W-1:0]         sat_gain_r;
  logic signed [SHIFT_W-1:0] hue_shift_r;
  logic                      push_valid;
  item_t                     push_item;
  item_t                     head_item;
  logic                      pop;
  q_status_t                 q_status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_gain_r  <= '0;
      hue_shift_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SAT_GAIN:  sat_gain_r  <= cfg_wdata[GAIN_W-1:0];
        REG_HUE_SHIFT: hue_shift_r <= $signed(cfg_wdata[SHIFT_W-1:0]);
        default: ;
      endcase
    end
  end

  whsb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_sat        (in_sat),
    .in_val        (in_val),
    .in_last_pixel (in_last_pixel),
    .q_status      (q_status),
    .push_valid    (push_valid),
    .push_item     (push_item)
  );

  whsb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .pop        (pop),
    .head_item  (head_item),
    .q_status   (q_status)
  );

  whsb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .sat_gain       (sat_gain_r),
    .hue_shift      (hue_shift_r),
    .head_item      (head_item),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_sat        (out_sat),
    .out_value      (out_value),
    .out_last_pixel (out_last_pixel)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import whsb_pkg::*;

  localparam int HOLD_OFF_CYCLES = 40;
  localparam int STALL_LIMIT     = 1000;
  localparam int PHASE_PIXELS    = 110;
  localparam int N_PHASES        = 8;
  localparam int N_FIXED         = 5;
  localparam int TAIL_CYCLES     = 8;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  // Register settings of the first phases: off, both extremes, unity, smallest steps.
  localparam logic [GAIN_W-1:0]  FIXED_GAIN  [N_FIXED] =
    '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h4000, 16'h0001};
  localparam logic [SHIFT_W-1:0] FIXED_SHIFT [N_FIXED] =
    '{16'h0000, 16'h7FFF, 16'h8000, 16'h0100, 16'hFFFF};

  // One pixel word as it crosses either channel.
  typedef struct packed {
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] sat;
    logic [PIX_W-1:0] value;
    logic             last;
  } hsv_word_t;

  // Predicts each boosted pixel and checks the block's words in order.
  class boost_scoreboard;
    logic [GAIN_W-1:0]         gain;
    logic signed [SHIFT_W-1:0] shift;
    hsv_word_t                 expected_pixels[$];
    int                        mismatches;
    int                        words_checked;

    function new();
      gain          = '0;
      shift         = '0;
      mismatches    = 0;
      words_checked = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
    endtask

    function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SAT_GAIN:  gain  = data;
        REG_HUE_SHIFT: shift = data;
        default: ;
      endcase
    endfunction

    function longint limit_to(longint x, longint span);
      if (x < 0) return 0;
      if (x > span) return span;
      return x;
    endfunction

    // Smoothstep of m over 0..span, scaled to 2^F.
    function longint smooth(longint m, longint span);
      return ((m * m * (3 * span - 2 * m)) << WEIGHT_FRAC_BITS) / (span * span * span);
    endfunction

    // The warm band weight is a smoothstep of the product of the two ramps.
    function longint warm_weight(logic [PIX_W-1:0] h);
      longint a;
      longint b;
      if (h >= HUE_MOD) return 0;
      a = limit_to(longint'(h) - HUE_LO, HUE_RAMP);
      b = limit_to(HUE_HI - longint'(h), HUE_RAMP);
      return smooth(a * b, HUE_RAMP * HUE_RAMP);
    endfunction

    function hsv_word_t boost_pixel(hsv_word_t px);
      hsv_word_t res;
      longint    hw;
      longint    sw;
      longint    vw;
      longint    cw;
      longint    fac;
      longint    s2;
      longint    scale;
      longint    span;
      longint    moved;
      res = px;
      hw  = warm_weight(px.hue);
      // Saturation gain grows with the warm weight.
      if (gain != 0) begin
        fac = (longint'(1) << (GAIN_FRAC_BITS + WEIGHT_FRAC_BITS)) + longint'(gain) * hw;
        s2  = (longint'(px.sat) * fac) >> (GAIN_FRAC_BITS + WEIGHT_FRAC_BITS);
        res.sat = (s2 > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(s2);
      end
      // Hue moves by the shift times all three weights, wrapped into one turn.
      if (shift != 0) begin
        sw    = smooth(limit_to(longint'(px.sat) - SAT_LO, SAT_SPAN), SAT_SPAN);
        vw    = smooth(limit_to(longint'(px.value) - VAL_LO, VAL_SPAN), VAL_SPAN);
        cw    = (((hw * sw) >> WEIGHT_FRAC_BITS) * vw) >> WEIGHT_FRAC_BITS;
        scale = longint'(1) << (SHIFT_FRAC_BITS + WEIGHT_FRAC_BITS);
        span  = HUE_MOD * scale;
        moved = (longint'(px.hue) * scale + longint'(shift) * cw) % span;
        if (moved < 0) moved += span;
        res.hue = PIX_W'(moved / scale);
      end
      return res;
    endfunction

    function void note_pixel_in(hsv_word_t px);
      expected_pixels.push_back(boost_pixel(px));
    endfunction

    task check_pixel_out(hsv_word_t got);
      hsv_word_t want;
      if (expected_pixels.size() == 0) begin
        report("word with nothing expected, hue", got.hue, 0);
        return;
      end
      want = expected_pixels.pop_front();
      words_checked++;
      if (got.hue !== want.hue) report("hue", got.hue, want.hue);
      if (got.sat !== want.sat) report("saturation", got.sat, want.sat);
      if (got.value !== want.value) report("value", got.value, want.value);
      if (got.last !== want.last) report("last pixel mark", got.last, want.last);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_hue;
  logic [PIX_W-1:0]      in_sat;
  logic [PIX_W-1:0]      in_val;
  logic                  in_last_pixel;
  logic                  out_valid;
  logic                  out_stall;
  logic [PIX_W-1:0]      out_hue;
  logic [PIX_W-1:0]      out_sat;
  logic [PIX_W-1:0]      out_value;
  logic                  out_last_pixel;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  boost_scoreboard sb;
  int              send_idle_pct;
  int              recv_stall_pct;
  logic            hold_req;
  int              idle_cycles;
  int              pixels_sent;
  int              settings_used;

  warm_hue_saturation_boost i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_hue         (in_hue),
    .in_sat         (in_sat),
    .in_val         (in_val),
    .in_last_pixel  (in_last_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_sat        (out_sat),
    .out_value      (out_value),
    .out_last_pixel (out_last_pixel),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // The receiver stalls at random, or holds off for a long stretch on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      out_stall = ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Every word taken from the block is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_pixel_out({out_hue, out_sat, out_value, out_last_pixel});
    end
  end

  // The run ends as failed when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t no word moved for %0d cycles", $realtime, idle_cycles);
      $display("tb failed");
      $finish;
    end
  end

  // Offers one word after a random gap and notes it once the block takes it.
  task automatic send_pixel(input logic [PIX_W-1:0] h, input logic [PIX_W-1:0] s,
                            input logic [PIX_W-1:0] v, input logic l);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_hue        = h;
    in_sat        = s;
    in_val        = v;
    in_last_pixel = l;
    do @(posedge clk); while (in_stall);
    sb.note_pixel_in({h, s, v, l});
    pixels_sent++;
  endtask

  // Stops offering and waits until every predicted word has come back.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    sb.note_reg(idx, data);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Sets both registers, then writes the unused indexes to show they are ignored.
  task automatic program_boost(input logic [GAIN_W-1:0] g, input logic [SHIFT_W-1:0] sh);
    write_reg(REG_SAT_GAIN, g);
    write_reg(REG_HUE_SHIFT, sh);
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    settings_used++;
  endtask

  initial begin
    logic [GAIN_W-1:0]  g;
    logic [SHIFT_W-1:0] sh;
    logic [PIX_W-1:0]   h;
    logic [PIX_W-1:0]   s;
    logic [PIX_W-1:0]   v;
    logic               l;
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_hue         = '0;
    in_sat         = '0;
    in_val         = '0;
    in_last_pixel  = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = REG_SAT_GAIN;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    pixels_sent    = 0;
    settings_used  = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Out of reset both features are off: every word passes, even hue above 179.
    send_pixel(8'd200, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd20, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    drain();

    // Full gain and the most negative shift: band edges, ramps and wrap below zero.
    program_boost(16'hFFFF, 16'h8000);
    send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd5, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd6, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd11, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd12, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd32, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd38, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd39, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd179, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd180, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd200, 8'd130, 1'b1);
    send_pixel(8'd20, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd20, 8'd80, 8'd255, 1'b0);
    send_pixel(8'd20, 8'd95, 8'd255, 1'b0);
    send_pixel(8'd20, 8'd110, 8'd255, 1'b0);
    send_pixel(8'd20, 8'd255, 8'd100, 1'b0);
    send_pixel(8'd20, 8'd255, 8'd120, 1'b0);
    send_pixel(8'd20, 8'd255, 8'd140, 1'b0);
    send_pixel(8'd20, 8'd255, 8'd0, 1'b1);
    drain();

    // Random words under several settings, each phase with one of four idling patterns.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      if (ph < N_FIXED) begin
        g  = FIXED_GAIN[ph];
        sh = FIXED_SHIFT[ph];
      end else begin
        g  = GAIN_W'($urandom);
        sh = SHIFT_W'($urandom);
      end
      program_boost(g, sh);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        // Most hues fall in the valid turn, many in the warm band around its ramps.
        case ($urandom_range(0, 9))
          0, 1, 2, 3: h = PIX_W'($urandom_range(0, 45));
          9:          h = PIX_W'($urandom_range(0, 255));
          default:    h = PIX_W'($urandom_range(0, HUE_MOD - 1));
        endcase
        s = $urandom_range(0, 1) ? PIX_W'($urandom_range(70, 120)) : PIX_W'($urandom);
        v = $urandom_range(0, 1) ? PIX_W'($urandom_range(90, 150)) : PIX_W'($urandom);
        l = ($urandom_range(0, 7) == 0);
        send_pixel(h, s, v, l);
        // The receiver holds off while words keep coming, so the block backs up.
        if (ph % 4 == 0 && i == 30) hold_req = 1'b1;
        if (ph == 1 && i == 55) drain();
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.expected_pixels.size() != 0) begin
      sb.report("words never delivered", sb.expected_pixels.size(), 0);
    end
    $display("Sent %0d pixels and checked %0d words over %0d register settings,",
             pixels_sent, sb.words_checked, settings_used);
    $display("with idle, stalled, held-off and back-to-back traffic; %0d mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
